[sv/jtd_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the
// job target dispatcher. No dependencies.
package jtd_pkg;

  localparam int NUM_CPUS   = 16;
  localparam int COUNT_BITS = 8;
  localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int MASK_W     = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // op codes
  localparam logic [1:0] OP_QUEUE    = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_CALLIN   = 2'd2;

  // status codes
  localparam logic [1:0] ST_QUEUED = 2'd0;
  localparam logic [1:0] ST_LOCAL  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_ACK    = 2'd3;

  // configuration register indexes
  localparam logic REG_AVAILABLE = 1'b0;
  localparam logic REG_PRIMARY   = 1'b1;

  typedef struct packed {
    logic load;       // latch a new transaction, clear scan state
    logic scan_step;  // examine one processor entry, advance the index
    logic resolve;    // settle the target and action
    logic update;     // read-modify-write the target entry, drive the result
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;  // queue request with no explicit target
    logic scan_last;  // scan index is at the last processor
  } dp_stat_t;

endpackage

[sv/jtd_ctrl.sv]
// Sequencing state machine of the job target dispatcher.
// Depends on jtd_pkg for the command and status structs.
module jtd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output jtd_pkg::dp_cmd_t cmd,
  input  jtd_pkg::dp_stat_t stat
);
  import jtd_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;
  localparam logic [2:0] S_UPDATE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = stat.need_scan ? S_SCAN : S_RESOLVE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[sv/jtd_dpath.sv]
// Datapath of the job target dispatcher: per-processor count and flag store,
// scan accumulators, target resolution and result registers. Uses jtd_pkg.
module jtd_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jtd_pkg::dp_cmd_t      cmd,
  output jtd_pkg::dp_stat_t     stat,
  input  logic [1:0]            in_op,
  input  logic [3:0]            in_requester_cpu,
  input  logic                  in_target_given,
  input  logic [3:0]            in_target_cpu,
  input  logic                  in_job_no_return,
  input  logic [jtd_pkg::MASK_W-1:0] avail_mask,
  input  logic [jtd_pkg::MASK_W-1:0] prim_mask,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [3:0]            out_chosen_cpu,
  output logic                  out_no_return_warning,
  output logic [7:0]            out_count_after,
  output logic                  out_count_saturated
);
  import jtd_pkg::*;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_QUEUE  = 3'd1;
  localparam logic [2:0] ACT_LOCAL  = 3'd2;
  localparam logic [2:0] ACT_REJECT = 3'd3;
  localparam logic [2:0] ACT_DEC    = 3'd4;
  localparam logic [2:0] ACT_CLR    = 3'd5;

  // per-processor state
  logic [COUNT_BITS-1:0] cnt_r [NUM_CPUS];
  logic [NUM_CPUS-1:0]   flag_r;

  // latched transaction
  logic [1:0] op_r;
  logic [3:0] req_r;
  logic       given_r;
  logic [3:0] tgt_r;
  logic       nret_r;

  // scan state
  logic [CPU_W-1:0]      scan_idx_r;
  logic                  fp_v_r, fi_v_r, best_v_r;
  logic [CPU_W-1:0]      fp_idx_r, fi_idx_r, best_idx_r;
  logic [COUNT_BITS-1:0] best_cnt_r;

  // resolved action
  logic [2:0]       act_r;
  logic [CPU_W-1:0] idx_r;

  // result registers
  logic       valid_r;
  logic [1:0] status_r;
  logic [3:0] chosen_r;
  logic       warn_r;
  logic [7:0] cnt_out_r;
  logic       sat_r;

  // single read port of the entry store
  logic [CPU_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_flag;
  logic                  eligible;
  logic                  tgt_in_range;
  logic                  tgt_avail;

  assign rd_addr = cmd.scan_step ? scan_idx_r : idx_r;
  assign rd_cnt  = cnt_r[rd_addr];
  assign rd_flag = flag_r[rd_addr];

  assign eligible = (32'(scan_idx_r) < MASK_W) && avail_mask[4'(scan_idx_r)]
                    && (32'(scan_idx_r) != 32'(req_r)) && !rd_flag;

  assign tgt_in_range = (32'(tgt_r) < NUM_CPUS);
  assign tgt_avail    = tgt_in_range && avail_mask[tgt_r];

  assign stat.need_scan = (op_r == OP_QUEUE) && !given_r;
  assign stat.scan_last = (scan_idx_r == CPU_W'(NUM_CPUS - 1));

  // transaction latch and scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      req_r   <= in_requester_cpu;
      given_r <= in_target_given;
      tgt_r   <= in_target_cpu;
      nret_r  <= in_job_no_return;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      fp_v_r     <= 1'b0;
      fi_v_r     <= 1'b0;
      best_v_r   <= 1'b0;
    end else if (cmd.load) begin
      scan_idx_r <= '0;
      fp_v_r     <= 1'b0;
      fi_v_r     <= 1'b0;
      best_v_r   <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (eligible) begin
        if (rd_cnt == '0 && prim_mask[4'(scan_idx_r)] && (32'(scan_idx_r) < MASK_W)
            && !fp_v_r) begin
          fp_v_r <= 1'b1;
        end
        if (rd_cnt == '0 && !fi_v_r) begin
          fi_v_r <= 1'b1;
        end
        if (!best_v_r || rd_cnt < best_cnt_r) begin
          best_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && eligible) begin
      if (rd_cnt == '0 && prim_mask[4'(scan_idx_r)] && (32'(scan_idx_r) < MASK_W)
          && !fp_v_r) begin
        fp_idx_r <= scan_idx_r;
      end
      if (rd_cnt == '0 && !fi_v_r) begin
        fi_idx_r <= scan_idx_r;
      end
      if (!best_v_r || rd_cnt < best_cnt_r) begin
        best_idx_r <= scan_idx_r;
        best_cnt_r <= rd_cnt;
      end
    end
  end

  // target: given, else first idle primary, first idle, least loaded, local
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      idx_r <= CPU_W'(tgt_r);
      case (op_r)
        OP_QUEUE: begin
          if (given_r) begin
            if (!tgt_avail) begin
              act_r <= ACT_REJECT;
            end else if (tgt_r == req_r) begin
              act_r <= ACT_LOCAL;
            end else begin
              act_r <= ACT_QUEUE;
            end
          end else if (fp_v_r) begin
            act_r <= ACT_QUEUE;
            idx_r <= fp_idx_r;
          end else if (fi_v_r) begin
            act_r <= ACT_QUEUE;
            idx_r <= fi_idx_r;
          end else if (best_v_r) begin
            act_r <= ACT_QUEUE;
            idx_r <= best_idx_r;
          end else begin
            act_r <= ACT_LOCAL;
          end
        end
        OP_COMPLETE: act_r <= tgt_in_range ? ACT_DEC : ACT_NONE;
        OP_CALLIN:   act_r <= tgt_in_range ? ACT_CLR : ACT_NONE;
        default:     act_r <= ACT_NONE;
      endcase
    end
  end

  // read-modify-write of the target entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        cnt_r[i] <= '0;
      end
      flag_r <= '0;
    end else if (cmd.update) begin
      case (act_r)
        ACT_QUEUE: begin
          if (nret_r) begin
            flag_r[idx_r] <= 1'b1;
          end else if (rd_cnt != COUNT_MAX) begin
            cnt_r[idx_r] <= rd_cnt + 1'b1;
          end
        end
        ACT_DEC: begin
          if (rd_cnt != '0) begin
            cnt_r[idx_r] <= rd_cnt - 1'b1;
          end
        end
        ACT_CLR: flag_r[idx_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      chosen_r  <= tgt_r;
      status_r  <= ST_ACK;
      warn_r    <= 1'b0;
      cnt_out_r <= '0;
      sat_r     <= 1'b0;
      case (act_r)
        ACT_QUEUE: begin
          status_r <= ST_QUEUED;
          chosen_r <= 4'(idx_r);
          warn_r   <= rd_flag;
          if (nret_r) begin
            cnt_out_r <= 8'(rd_cnt);
          end else if (rd_cnt == COUNT_MAX) begin
            cnt_out_r <= 8'(rd_cnt);
            sat_r     <= 1'b1;
          end else begin
            cnt_out_r <= 8'(rd_cnt + 1'b1);
          end
        end
        ACT_LOCAL: begin
          status_r <= ST_LOCAL;
          chosen_r <= req_r;
        end
        ACT_REJECT: status_r <= ST_REJECT;
        ACT_DEC: cnt_out_r <= 8'((rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt);
        ACT_CLR: cnt_out_r <= 8'(rd_cnt);
        default: ;
      endcase
    end
  end

  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_chosen_cpu        = chosen_r;
  assign out_no_return_warning = warn_r;
  assign out_count_after       = cnt_out_r;
  assign out_count_saturated   = sat_r;

endmodule

[sv/job_target_dispatcher_unit.sv]
// Job target dispatcher top level: configuration registers, controller and
// datapath. Depends on jtd_pkg, jtd_ctrl and jtd_dpath.
// A transaction needing a target search passes decode, scan, resolve and update,
// scanning the entry store one processor a cycle; all others skip the scan.
// out_valid is registered from the update step. busy falls as out_valid rises,
// so a new transaction is taken only after the previous one has finished.
// rst_n (synchronous) zeroes every count and flag, sets available_mask to 0
// and primary_mask to all ones; the result port cannot be stalled.
module job_target_dispatcher_unit (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_requester_cpu,
  input  logic        in_target_given,
  input  logic [3:0]  in_target_cpu,
  input  logic        in_job_no_return,
  // result channel, one cycle strobe
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_chosen_cpu,
  output logic        out_no_return_warning,
  output logic [7:0]  out_count_after,
  output logic        out_count_saturated,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jtd_pkg::*;

  logic [MASK_W-1:0] avail_r, prim_r;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // Register select is paddr[2]: available_mask at 0, primary_mask at 4.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= '0;
      prim_r  <= '1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_AVAILABLE: avail_r <= pwdata[MASK_W-1:0];
        REG_PRIMARY:   prim_r  <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended to the bus.
  always_comb begin
    case (paddr[2])
      REG_AVAILABLE: prdata = 32'(avail_r);
      REG_PRIMARY:   prdata = 32'(prim_r);
      default:       prdata = '0;
    endcase
  end

  // Controller: idle, decode, scan, resolve, update.
  jtd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Datapath: entry store, scan accumulators, result registers.
  jtd_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_op                 (in_op),
    .in_requester_cpu      (in_requester_cpu),
    .in_target_given       (in_target_given),
    .in_target_cpu         (in_target_cpu),
    .in_job_no_return      (in_job_no_return),
    .avail_mask            (avail_r),
    .prim_mask             (prim_r),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_chosen_cpu        (out_chosen_cpu),
    .out_no_return_warning (out_no_return_warning),
    .out_count_after       (out_count_after),
    .out_count_saturated   (out_count_saturated)
  );

endmodule
